// File: rtl/fwr_pkg.sv
// Shared types and constants for the FIFO way replacement block.
// Used by fifo_way_replacement_core, fwr_checker and the testbench; no dependencies.
package fwr_pkg;

  // Cache geometry and counter width
  localparam int SETS      = 64;
  localparam int WAYS      = 16;
  localparam int AGE_BITS  = 8;
  localparam int MASK_BITS = 16;

  // Derived widths
  localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W     = $clog2(WAYS);
  localparam int CNT_W     = $clog2(WAYS + 1);
  localparam int ADDR_W    = SET_W + WAY_W;
  localparam int AGE_DEPTH = 2 ** ADDR_W;
  localparam int MASK_WAYS = (WAYS < MASK_BITS) ? WAYS : MASK_BITS;

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  // Request codes
  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [5:0]  set_index;
    logic [3:0]  fill_way;
    logic        hit;
    logic [15:0] valid_mask;
  } in_word_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic       victim_was_invalid;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_AGE,
    ST_FINISH
  } state_t;

endpackage

// File: rtl/fwr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module fwr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/fifo_way_replacement_core.sv
// FIFO way replacement core: age RAM, one-way-per-cycle sequencer, result register.
// Depends on fwr_pkg and fwr_ram.

// One request at a time. A victim request whose valid mask shows an invalid way,
// and an update that hits (or names a way beyond the set), skip the walk.
// A victim request on a full set and a miss update walk the set's ages through
// the age RAM one way per cycle, using a single compare/increment unit; the single
// RAM read port sets that rate. The input stalls while a request is in flight; a
// finished result waits in the output register and the next request is taken
// meanwhile. Ages reset to zero at once: a per-set flag marks sets never updated,
// which read as all zero, so no clearing pass is needed after reset.
module fifo_way_replacement_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fwr_pkg::in_word_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fwr_pkg::out_word_t out_data
);

  fwr_pkg::state_t state_r, state_nxt;

  // Request held during the walk
  logic                         op_r;
  logic [fwr_pkg::SET_W-1:0]    set_r;
  logic [3:0]                   fill_r;

  // Walk counters
  logic [fwr_pkg::CNT_W-1:0]    cnt_r;
  logic                         dvalid_r;
  logic [fwr_pkg::WAY_W-1:0]    dway_r;

  // Running maximum
  logic [fwr_pkg::AGE_BITS-1:0] best_age_r;
  logic [fwr_pkg::WAY_W-1:0]    best_way_r;

  // Pending result and output register
  fwr_pkg::out_word_t           res_r;
  logic                         out_valid_r;
  fwr_pkg::out_word_t           out_data_r;

  // Sets that have seen a miss update since reset
  logic [fwr_pkg::SETS-1:0]     row_valid_r;

  logic                         accept;
  logic                         inv_found;
  logic [fwr_pkg::WAY_W-1:0]    inv_way;
  logic                         upd_skip;
  logic [fwr_pkg::SET_W-1:0]    in_set;
  logic                         rd_en;
  logic                         last_way;
  logic [fwr_pkg::AGE_BITS-1:0] ram_rdata;
  logic [fwr_pkg::AGE_BITS-1:0] age;
  logic                         take_best;
  logic                         ram_we;
  logic [fwr_pkg::AGE_BITS-1:0] ram_wdata;
  logic                         out_free;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_set   = fwr_pkg::SET_W'(in_data.set_index);
  assign upd_skip = in_data.hit || (32'(in_data.fill_way) >= fwr_pkg::WAYS);

  // Find the lowest invalid way named by the mask
  always_comb begin
    inv_found = 1'b0;
    inv_way   = '0;
    for (int i = fwr_pkg::MASK_WAYS - 1; i >= 0; i--) begin
      if (!in_data.valid_mask[i]) begin
        inv_found = 1'b1;
        inv_way   = fwr_pkg::WAY_W'(i);
      end
    end
  end

  // Age walk: read one way per cycle, process it the cycle after
  assign rd_en    = ((state_r == fwr_pkg::ST_SCAN) || (state_r == fwr_pkg::ST_AGE)) &&
                    (cnt_r < fwr_pkg::CNT_W'(fwr_pkg::WAYS));
  assign last_way = dvalid_r && (dway_r == fwr_pkg::WAY_W'(fwr_pkg::WAYS - 1));
  assign age      = row_valid_r[set_r] ? ram_rdata : '0;

  // Shared compare / increment unit
  assign take_best = (dway_r == '0) || (age > best_age_r);
  assign ram_we    = dvalid_r && (state_r == fwr_pkg::ST_AGE);
  always_comb begin
    if (32'(dway_r) == 32'(fill_r)) begin
      ram_wdata = '0;
    end else if (age == fwr_pkg::AGE_MAX) begin
      ram_wdata = age;
    end else begin
      ram_wdata = age + fwr_pkg::AGE_BITS'(1);
    end
  end

  fwr_ram #(
    .WIDTH (fwr_pkg::AGE_BITS),
    .DEPTH (fwr_pkg::AGE_DEPTH)
  ) u_age_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({set_r, dway_r}),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr ({set_r, cnt_r[fwr_pkg::WAY_W-1:0]}),
    .rdata (ram_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fwr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and handshake
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    case (state_r)
      fwr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_data.operation == fwr_pkg::OP_VICTIM) begin
            state_nxt = inv_found ? fwr_pkg::ST_FINISH : fwr_pkg::ST_SCAN;
          end else begin
            state_nxt = upd_skip ? fwr_pkg::ST_FINISH : fwr_pkg::ST_AGE;
          end
        end
      end
      fwr_pkg::ST_SCAN, fwr_pkg::ST_AGE: begin
        if (last_way) begin
          state_nxt = fwr_pkg::ST_FINISH;
        end
      end
      fwr_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = fwr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fwr_pkg::ST_IDLE;
    endcase
  end

  // Capture request, advance the walk, track the oldest way
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_data.operation;
      set_r    <= in_set;
      fill_r   <= in_data.fill_way;
      cnt_r    <= '0;
      dvalid_r <= 1'b0;
      if ((in_data.operation == fwr_pkg::OP_VICTIM) && inv_found) begin
        res_r <= '{victim_way: 4'(inv_way), victim_was_invalid: 1'b1};
      end else begin
        res_r <= '0;
      end
    end else begin
      dvalid_r <= rd_en;
      dway_r   <= cnt_r[fwr_pkg::WAY_W-1:0];
      if (rd_en) begin
        cnt_r <= cnt_r + fwr_pkg::CNT_W'(1);
      end
      if (dvalid_r && (state_r == fwr_pkg::ST_SCAN) && take_best) begin
        best_age_r <= age;
        best_way_r <= dway_r;
      end
      if (last_way && (op_r == fwr_pkg::OP_VICTIM)) begin
        res_r <= '{victim_way: (take_best ? 4'(dway_r) : 4'(best_way_r)),
                   victim_was_invalid: 1'b0};
      end
    end
  end

  // Mark a set as holding real ages once its walk writes it back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (ram_we && last_way) begin
      row_valid_r[set_r] <= 1'b1;
    end
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == fwr_pkg::ST_FINISH) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == fwr_pkg::ST_FINISH) && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The age RAM is written only during a miss update walk
  a_write_in_age: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == fwr_pkg::ST_AGE))
    else $error("age RAM written outside update walk");

  // No read data is in flight outside a walk
  a_no_stray_data: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == fwr_pkg::ST_IDLE) || (state_r == fwr_pkg::ST_FINISH)) |-> !dvalid_r)
    else $error("walk data pending outside walk");

  // A new result appears only after the finish step
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == fwr_pkg::ST_FINISH))
    else $error("result produced outside finish step");

endmodule

// File: sim/fwr_checker.sv
// Checker for fifo_way_replacement_core: tracks per-set way ages and predicts each result word.
// Depends on fwr_pkg; instantiated beside the block by tb_fifo_way_replacement_core.
`timescale 1ns / 100ps

module fwr_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  fwr_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  fwr_pkg::out_word_t out_data,
  output int                 fail_count,
  output int                 pending
);

  // Age of every way in every set, as the block should hold it
  logic [fwr_pkg::AGE_BITS-1:0] way_age [fwr_pkg::SETS][fwr_pkg::WAYS];
  fwr_pkg::out_word_t           due_victims [$];
  fwr_pkg::out_word_t           want;
  int                           errors = 0;

  // Choose a victim or age a set; return the word the block must answer with
  function automatic fwr_pkg::out_word_t predict_replacement(input fwr_pkg::in_word_t req);
    int unsigned        set_sel;
    int                 best;
    bit                 found;
    fwr_pkg::out_word_t res;
    set_sel = req.set_index % fwr_pkg::SETS;
    res     = '0;
    if (req.operation == fwr_pkg::OP_VICTIM) begin
      found = 1'b0;
      // lowest invalid way wins; ways past the mask count as valid
      for (int i = 0; i < fwr_pkg::WAYS; i++) begin
        if (!found && i < fwr_pkg::MASK_BITS && !req.valid_mask[i]) begin
          found                  = 1'b1;
          res.victim_way         = 4'(i);
          res.victim_was_invalid = 1'b1;
        end
      end
      // full set: oldest way, lowest on a tie
      if (!found) begin
        best = 0;
        for (int i = 1; i < fwr_pkg::WAYS; i++) begin
          if (way_age[set_sel][i] > way_age[set_sel][best]) best = i;
        end
        res.victim_way = 4'(best);
      end
    end else if (!req.hit && req.fill_way < fwr_pkg::WAYS) begin
      // miss: age the whole set with saturation, then restart the filled way
      for (int i = 0; i < fwr_pkg::WAYS; i++) begin
        if (way_age[set_sel][i] != fwr_pkg::AGE_MAX)
          way_age[set_sel][i] = way_age[set_sel][i] + 1'b1;
      end
      way_age[set_sel][req.fill_way] = '0;
    end
    return res;
  endfunction

  // Compare finished words, then queue the prediction for a newly taken word
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (way_age[s, w]) way_age[s][w] = '0;
      due_victims.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_victims.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result word way=%0d invalid=%0d", $realtime,
                     out_data.victim_way, out_data.victim_was_invalid);
        end else begin
          want = due_victims.pop_front();
          if (out_data.victim_way !== want.victim_way ||
              out_data.victim_was_invalid !== want.victim_was_invalid) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: expected way=%0d invalid=%0d, got way=%0d invalid=%0d",
                       $realtime, want.victim_way, want.victim_was_invalid,
                       out_data.victim_way, out_data.victim_was_invalid);
          end
        end
      end
      if (in_valid && !in_stall) due_victims.push_back(predict_replacement(in_data));
      fail_count <= errors;
      pending    <= due_victims.size();
    end
  end

endmodule

// File: sim/tb_fifo_way_replacement_core.sv
// Top of the testbench for fifo_way_replacement_core: clock, reset, request stimulus, verdict.
// Depends on fwr_pkg, fifo_way_replacement_core and fwr_checker.
`timescale 1ns / 100ps

module tb_fifo_way_replacement_core;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  fwr_pkg::in_word_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  fwr_pkg::out_word_t out_data;
  int                 fail_count;
  int                 pending;
  int                 send_gap_pct  = 0;
  int                 recv_stall_pct = 0;

  fifo_way_replacement_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  fwr_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #5_000_000;
    $display("tb_fifo_way_replacement_core: errors");
    $finish;
  end

  // Stall the result channel at the current rate
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  function automatic fwr_pkg::in_word_t make_word(logic op, logic [5:0] set_idx,
                                                  logic [3:0] way, logic was_hit,
                                                  logic [15:0] mask);
    fwr_pkg::in_word_t w;
    w.operation  = op;
    w.set_index  = set_idx;
    w.fill_way   = way;
    w.hit        = was_hit;
    w.valid_mask = mask;
    return w;
  endfunction

  // Offer one word, idling first at random; hold it until taken
  task automatic send_word(input fwr_pkg::in_word_t w);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random traffic, mostly on a few busy sets, half with full masks so ages matter
  task automatic run_random(input int count);
    logic [5:0]  set_idx;
    logic [15:0] mask;
    for (int k = 0; k < count; k++) begin
      set_idx = ($urandom_range(99) < 70) ? 6'($urandom_range(3) + 60) : 6'($urandom);
      case ($urandom_range(3))
        0, 1:    mask = '1;
        2:       mask = ~(16'h1 << $urandom_range(15));
        default: mask = 16'($urandom);
      endcase
      send_word(make_word(1'($urandom_range(1)), set_idx, 4'($urandom),
                          $urandom_range(99) < 25, mask));
    end
  endtask

  initial begin
    logic [5:0] hot;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: sender gaps seldom, receiver stalls often
    send_gap_pct   = 10;
    recv_stall_pct = 46;

    // Directed: mask extremes, fresh sets, hits, and age ordering with ties
    send_word(make_word(fwr_pkg::OP_VICTIM, 6'd0,  4'd0,  1'b0, 16'hFFFF));
    send_word(make_word(fwr_pkg::OP_VICTIM, 6'd63, 4'd15, 1'b1, 16'h0000));
    send_word(make_word(fwr_pkg::OP_VICTIM, 6'd5,  4'd0,  1'b0, 16'h7FFF));
    send_word(make_word(fwr_pkg::OP_VICTIM, 6'd5,  4'd0,  1'b0, 16'hFFFE));
    send_word(make_word(fwr_pkg::OP_VICTIM, 6'd9,  4'd0,  1'b0, 16'hFF00));
    send_word(make_word(fwr_pkg::OP_UPDATE, 6'd63, 4'd15, 1'b0, 16'h0000));
    send_word(make_word(fwr_pkg::OP_UPDATE, 6'd63, 4'd3,  1'b1, 16'hFFFF));
    send_word(make_word(fwr_pkg::OP_VICTIM, 6'd63, 4'd7,  1'b1, 16'hFFFF));
    send_word(make_word(fwr_pkg::OP_UPDATE, 6'd63, 4'd0,  1'b0, 16'hA5A5));
    send_word(make_word(fwr_pkg::OP_VICTIM, 6'd63, 4'd0,  1'b0, 16'hFFFF));
    send_word(make_word(fwr_pkg::OP_UPDATE, 6'd63, 4'd1,  1'b0, 16'h0000));
    send_word(make_word(fwr_pkg::OP_UPDATE, 6'd63, 4'd2,  1'b0, 16'h0000));
    send_word(make_word(fwr_pkg::OP_VICTIM, 6'd63, 4'd0,  1'b0, 16'hFFFF));
    send_word(make_word(fwr_pkg::OP_UPDATE, 6'd63, 4'd3,  1'b0, 16'hFFFF));
    send_word(make_word(fwr_pkg::OP_VICTIM, 6'd63, 4'd0,  1'b0, 16'hFFFF));
    send_word(make_word(fwr_pkg::OP_VICTIM, 6'd63, 4'd0,  1'b0, 16'hBFFF));
    send_word(make_word(fwr_pkg::OP_UPDATE, 6'd0,  4'd15, 1'b1, 16'h0000));
    send_word(make_word(fwr_pkg::OP_VICTIM, 6'd0,  4'd0,  1'b0, 16'hFFFF));

    // Saturation: keep missing one set without filling its two top ways
    hot = 6'($urandom);
    for (int k = 0; k < 285; k++) begin
      if (k % 15 == 14)
        send_word(make_word(fwr_pkg::OP_VICTIM, hot, 4'($urandom), 1'($urandom), 16'hFFFF));
      else
        send_word(make_word(fwr_pkg::OP_UPDATE, hot, 4'($urandom_range(13)), 1'b0,
                            16'($urandom)));
    end
    send_word(make_word(fwr_pkg::OP_UPDATE, hot, 4'd14, 1'b0, 16'hFFFF));
    send_word(make_word(fwr_pkg::OP_VICTIM, hot, 4'd0,  1'b0, 16'hFFFF));
    run_random(120);

    // Phase two: the other way round
    send_gap_pct   = 46;
    recv_stall_pct = 10;
    run_random(250);

    // Phase three: full rate both sides
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_random(250);
    in_valid <= 1'b0;

    // Drain, then allow a full request's latency for stray words
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_fifo_way_replacement_core: clean");
    else
      $display("tb_fifo_way_replacement_core: errors");
    $finish;
  end

endmodule

// File: files.f
rtl/fwr_pkg.sv
rtl/fwr_ram.sv
rtl/fifo_way_replacement_core.sv
sim/fwr_checker.sv
sim/tb_fifo_way_replacement_core.sv
